// File: src/cfga_pkg.sv
`default_nettype none

package cfga_pkg;

    localparam logic [1:0] OP_LOAD_REF  = 2'd0;
    localparam logic [1:0] OP_LOAD_READ = 2'd1;
    localparam logic [1:0] OP_RUN       = 2'd2;

    localparam logic [2:0] REG_ORF_START    = 3'd0;
    localparam logic [2:0] REG_ORF_END      = 3'd1;
    localparam logic [2:0] REG_FRAME_OFFSET = 3'd2;
    localparam logic [2:0] REG_REF_LENGTH   = 3'd3;
    localparam logic [2:0] REG_READ_LENGTH  = 3'd4;

    localparam logic [16:0] PENALTY_MAX = 17'h1FFFF;
    localparam logic [7:0]  AMINO_NONE  = 8'h3F;

    typedef enum logic [4:0] {
        S_IDLE,
        S_CHECK,
        S_LOOP,
        S_CMP,
        S_RUN_FWD,
        S_RUN_FWD_W,
        S_RUN_BWD,
        S_RUN_BWD_W,
        S_RUN_NEXT,
        S_HOMO_DIV,
        S_HOMO_APPLY,
        S_CAND,
        S_SUBST_D,
        S_SUBST_MUL,
        S_SUBST_CMP,
        S_TERM_A,
        S_TERM_B,
        S_TERM_C
    } state_t;

    localparam logic [7:0] AMINO_TAB [64] = '{
        "F","F","L","L","S","S","S","S","Y","Y","*","*","C","C","*","W",
        "L","L","L","L","P","P","P","P","H","H","Q","Q","R","R","R","R",
        "I","I","I","M","T","T","T","T","N","N","K","K","S","S","R","R",
        "V","V","V","V","A","A","A","A","D","D","E","E","G","G","G","G"
    };

    function automatic logic [2:0] base_code(input logic [7:0] b);
        logic [2:0] c;
        case (b)
            8'h54:   c = 3'd0;
            8'h43:   c = 3'd1;
            8'h41:   c = 3'd2;
            8'h47:   c = 3'd3;
            default: c = 3'd4;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] amino_of(input logic [7:0] b0, input logic [7:0] b1,
                                            input logic [7:0] b2);
        logic [2:0] c0;
        logic [2:0] c1;
        logic [2:0] c2;
        logic [7:0] a;
        c0 = base_code(b0);
        c1 = base_code(b1);
        c2 = base_code(b2);
        if (c0[2] || c1[2] || c2[2]) begin
            a = AMINO_NONE;
        end else begin
            a = AMINO_TAB[{c0[1:0], c1[1:0], c2[1:0]}];
        end
        return a;
    endfunction

endpackage

`default_nettype wire

// File: src/cfga_mem.sv
`default_nettype none

module cfga_mem #(
    parameter int AW = 14
) (
    input  wire logic          clk,
    input  wire logic          we,
    input  wire logic [AW-1:0] addr,
    input  wire logic [7:0]    wdata,
    output logic      [7:0]    rdata
);

    logic [7:0] mem [2**AW];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

`default_nettype wire

// File: src/cfga_div3.sv
`default_nettype none

// Registered floor(x / 3) by multiplication with a rounded-up reciprocal.
module cfga_div3 #(
    parameter int PW = 17
) (
    input  wire logic          clk,
    input  wire logic [PW-1:0] x,
    output logic      [PW-1:0] q
);

    localparam logic [PW-1:0] RECIP = PW'(((64'd1 << (PW + 1)) / 3) + 64'd1);

    logic [2*PW:0] prod;

    assign prod = (2*PW+1)'(x) * (2*PW+1)'(RECIP);

    always_ff @(posedge clk)
    begin
        q <= prod[2*PW:PW+1];
    end

endmodule

`default_nettype wire

// File: src/codon_frame_greedy_aligner_unit.sv
`default_nettype none

// Load commands leave busy low; a byte is written at the accepting edge.
// A run keeps busy high while the sequencer walks the codons: a codon compare makes one read
// per memory port per cycle, a homopolymer scan reads and tests one byte at a time, a frameshift
// search tries up to 24 candidate compares, and the termination check runs in S_TERM_A..S_TERM_C.
// The result is held on penalty/failed; done is high for exactly one cycle; the receiver cannot stall.
// Reset clears the controller, done and the configuration registers; memory contents are undefined until loaded.
module codon_frame_greedy_aligner_unit #(
    parameter int MAX_LEN = 16384
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  opcode,
    input  wire logic [13:0] address,
    input  wire logic [7:0]  base,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [14:0] cfg_data,
    output logic             done,
    output logic      [16:0] penalty,
    output logic             failed
);

    localparam int AW = $clog2(MAX_LEN);
    localparam int PW = (AW + 2 > 17) ? AW + 2 : 17;
    localparam int TW = PW + 3;
    localparam int LW = AW + 1;
    localparam logic [PW-1:0] MAX_P = PW'(MAX_LEN);

    cfga_pkg::state_t state_reg, state_next;

    logic [14:0] orf_start_reg, orf_end_reg, ref_length_reg, read_length_reg;
    logic [1:0]  frame_offset_reg;

    logic          done_reg, done_next;
    logic [16:0]   penalty_reg, penalty_next;
    logic          failed_reg, failed_next;

    logic [PW-1:0] i_reg, i_next, j_reg, j_next;
    logic [PW-1:0] cs_reg, cs_next, ce_reg, ce_next;
    logic [PW-1:0] rlen_reg, rlen_next, qlen_reg, qlen_next;
    logic [TW-1:0] total_reg, total_next;
    logic [PW-1:0] ca_reg, ca_next, cb_reg, cb_next;
    logic [1:0]    cmp_k_reg, cmp_k_next;
    logic          cmp_eq_reg, cmp_eq_next;
    logic          cmp_main_reg, cmp_main_next;
    logic [7:0]    r_reg [3];
    logic [7:0]    r_next [3];
    logic [7:0]    q_reg [3];
    logic [7:0]    q_next [3];
    logic          scan_sel_reg, scan_sel_next;
    logic [PW-1:0] scan_k_reg, scan_k_next, scan_n_reg, scan_n_next;
    logic [7:0]    scan_b_reg, scan_b_next;
    logic [PW-1:0] rh_reg, rh_next, h_reg, h_next;
    logic [2:0]    di_reg, di_next, dj_reg, dj_next;
    logic          found_reg, found_next;
    logic [2:0]    best_reg, best_next, bdi_reg, bdi_next, bdj_reg, bdj_next;
    logic [LW:0]   d_reg, d_next;
    logic [2*LW+1:0] dd_reg, dd_next;
    logic [2*LW-1:0] ll_reg, ll_next;
    logic [PW-1:0] q1_reg, q1_next;

    // Memory ports and shared divider.
    logic          ref_we, read_we, load_ok;
    logic [PW-1:0] ref_pos, read_pos;
    logic [7:0]    ref_rdata, read_rdata;
    logic [PW-1:0] div_x, div_q;

    // Decisions shared by the state and datapath blocks.
    logic [PW-1:0] rlen_w, qlen_w, cs_w;
    logic          bounds_bad, loop_ok;
    logic          byte_eq, cmp_eq_now, cand_better;
    logic [PW-1:0] scan_len, scan_p;
    logic [7:0]    sel_rdata;
    logic          fwd_stop, scan_hit;
    logic          rh3, qh3;
    logic [PW-1:0] ni, nj;
    logic          cand_end, cand_center, cand_in;
    logic [2:0]    adi, adj, shift_dist;
    logic          syn;
    logic [LW-1:0] lval;
    logic [LW:0]   two_j;
    logic          cost5;
    logic [PW-1:0] codons;
    logic [TW-1:0] codons5;
    logic          term_fail;
    logic [PW-1:0] skip;

    cfga_mem #(.AW(AW)) u_ref_mem (
        .clk   (clk),
        .we    (ref_we),
        .addr  (ref_pos[AW-1:0]),
        .wdata (base),
        .rdata (ref_rdata)
    );

    cfga_mem #(.AW(AW)) u_read_mem (
        .clk   (clk),
        .we    (read_we),
        .addr  (read_pos[AW-1:0]),
        .wdata (base),
        .rdata (read_rdata)
    );

    cfga_div3 #(.PW(PW)) u_div3 (
        .clk (clk),
        .x   (div_x),
        .q   (div_q)
    );

    assign busy    = (state_reg != cfga_pkg::S_IDLE);
    assign done    = done_reg;
    assign penalty = penalty_reg;
    assign failed  = failed_reg;

    assign load_ok = (state_reg == cfga_pkg::S_IDLE) && start && (32'(address) < MAX_LEN);
    assign ref_we  = load_ok && (opcode == cfga_pkg::OP_LOAD_REF);
    assign read_we = load_ok && (opcode == cfga_pkg::OP_LOAD_READ);

    always_comb
    begin
        rlen_w = (PW'(ref_length_reg) > MAX_P) ? MAX_P : PW'(ref_length_reg);
        qlen_w = (PW'(read_length_reg) > MAX_P) ? MAX_P : PW'(read_length_reg);
        cs_w   = PW'(orf_start_reg) + PW'(frame_offset_reg);
        bounds_bad = (PW'(orf_end_reg) > rlen_w) || (orf_start_reg >= orf_end_reg)
                     || (cs_w + PW'(3) > PW'(orf_end_reg));
        loop_ok = (i_reg + PW'(2) < ce_reg) && (j_reg + PW'(2) < qlen_reg);

        byte_eq    = (ref_rdata == read_rdata);
        cmp_eq_now = cmp_eq_reg && ((cmp_k_reg == 2'd0) || byte_eq);

        scan_len  = scan_sel_reg ? qlen_reg : rlen_reg;
        scan_p    = scan_sel_reg ? j_reg : i_reg;
        sel_rdata = scan_sel_reg ? read_rdata : ref_rdata;
        fwd_stop  = (scan_k_reg >= scan_len);
        scan_hit  = (sel_rdata == scan_b_reg);
        rh3       = (rh_reg >= PW'(3));
        qh3       = (scan_n_reg >= PW'(3));

        ni = i_reg + PW'(1) + PW'(di_reg);
        nj = j_reg + PW'(1) + PW'(dj_reg);
        cand_end    = (di_reg == 3'd5);
        cand_center = (di_reg == 3'd2) && (dj_reg == 3'd2);
        cand_in     = (ni >= cs_reg) && (ni + PW'(2) < ce_reg) && (nj + PW'(2) < qlen_reg);
        adi  = (di_reg >= 3'd2) ? di_reg - 3'd2 : 3'd2 - di_reg;
        adj  = (dj_reg >= 3'd2) ? dj_reg - 3'd2 : 3'd2 - dj_reg;
        shift_dist = adi + adj;
        cand_better = cmp_eq_now && (!found_reg || (shift_dist < best_reg));

        syn = (cfga_pkg::amino_of(r_reg[0], r_reg[1], r_reg[2])
               == cfga_pkg::amino_of(q_reg[0], q_reg[1], q_reg[2]));
        lval  = (qlen_reg == '0) ? LW'(1) : qlen_reg[LW-1:0];
        two_j = {j_reg[LW-1:0], 1'b0};
        cost5 = ((2*LW+5)'(dd_reg) * (2*LW+5)'(6)) <= (2*LW+5)'(ll_reg);

        codons    = (q1_reg > div_q) ? q1_reg : div_q;
        codons5   = (TW'(codons) << 2) + TW'(codons);
        term_fail = (codons > PW'(10)) && (total_reg > codons5);

        skip = (div_q << 1) + div_q;
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            cfga_pkg::S_IDLE:
            begin
                if (start && (opcode == cfga_pkg::OP_RUN))
                begin
                    state_next = cfga_pkg::S_CHECK;
                end
            end
            cfga_pkg::S_CHECK:
            begin
                state_next = bounds_bad ? cfga_pkg::S_IDLE : cfga_pkg::S_LOOP;
            end
            cfga_pkg::S_LOOP:
            begin
                state_next = loop_ok ? cfga_pkg::S_CMP : cfga_pkg::S_IDLE;
            end
            cfga_pkg::S_CMP:
            begin
                if (cmp_k_reg == 2'd3)
                begin
                    if (!cmp_main_reg)
                    begin
                        state_next = cfga_pkg::S_CAND;
                    end
                    else
                    begin
                        state_next = cmp_eq_now ? cfga_pkg::S_LOOP : cfga_pkg::S_RUN_FWD;
                    end
                end
            end
            cfga_pkg::S_RUN_FWD:
            begin
                state_next = fwd_stop ? cfga_pkg::S_RUN_BWD : cfga_pkg::S_RUN_FWD_W;
            end
            cfga_pkg::S_RUN_FWD_W:
            begin
                state_next = scan_hit ? cfga_pkg::S_RUN_FWD : cfga_pkg::S_RUN_BWD;
            end
            cfga_pkg::S_RUN_BWD:
            begin
                state_next = (scan_k_reg == '0) ? cfga_pkg::S_RUN_NEXT : cfga_pkg::S_RUN_BWD_W;
            end
            cfga_pkg::S_RUN_BWD_W:
            begin
                state_next = scan_hit ? cfga_pkg::S_RUN_BWD : cfga_pkg::S_RUN_NEXT;
            end
            cfga_pkg::S_RUN_NEXT:
            begin
                if (!scan_sel_reg)
                begin
                    state_next = cfga_pkg::S_RUN_FWD;
                end
                else
                begin
                    state_next = (rh3 || qh3) ? cfga_pkg::S_HOMO_DIV : cfga_pkg::S_CAND;
                end
            end
            cfga_pkg::S_HOMO_DIV:   state_next = cfga_pkg::S_HOMO_APPLY;
            cfga_pkg::S_HOMO_APPLY: state_next = cfga_pkg::S_LOOP;
            cfga_pkg::S_CAND:
            begin
                if (cand_end)
                begin
                    state_next = found_reg ? cfga_pkg::S_TERM_A : cfga_pkg::S_SUBST_D;
                end
                else if (!cand_center && cand_in)
                begin
                    state_next = cfga_pkg::S_CMP;
                end
            end
            cfga_pkg::S_SUBST_D:
            begin
                state_next = syn ? cfga_pkg::S_TERM_A : cfga_pkg::S_SUBST_MUL;
            end
            cfga_pkg::S_SUBST_MUL: state_next = cfga_pkg::S_SUBST_CMP;
            cfga_pkg::S_SUBST_CMP: state_next = cfga_pkg::S_TERM_A;
            cfga_pkg::S_TERM_A:    state_next = cfga_pkg::S_TERM_B;
            cfga_pkg::S_TERM_B:    state_next = cfga_pkg::S_TERM_C;
            cfga_pkg::S_TERM_C:
            begin
                state_next = term_fail ? cfga_pkg::S_IDLE : cfga_pkg::S_LOOP;
            end
            default: state_next = cfga_pkg::S_IDLE;
        endcase
    end

    // Datapath and outputs.
    always_comb
    begin
        done_next     = 1'b0;
        penalty_next  = penalty_reg;
        failed_next   = failed_reg;
        i_next        = i_reg;
        j_next        = j_reg;
        cs_next       = cs_reg;
        ce_next       = ce_reg;
        rlen_next     = rlen_reg;
        qlen_next     = qlen_reg;
        total_next    = total_reg;
        ca_next       = ca_reg;
        cb_next       = cb_reg;
        cmp_k_next    = cmp_k_reg;
        cmp_eq_next   = cmp_eq_reg;
        cmp_main_next = cmp_main_reg;
        r_next        = r_reg;
        q_next        = q_reg;
        scan_sel_next = scan_sel_reg;
        scan_k_next   = scan_k_reg;
        scan_n_next   = scan_n_reg;
        scan_b_next   = scan_b_reg;
        rh_next       = rh_reg;
        h_next        = h_reg;
        di_next       = di_reg;
        dj_next       = dj_reg;
        found_next    = found_reg;
        best_next     = best_reg;
        bdi_next      = bdi_reg;
        bdj_next      = bdj_reg;
        d_next        = d_reg;
        dd_next       = dd_reg;
        ll_next       = ll_reg;
        q1_next       = q1_reg;
        ref_pos       = PW'(address);
        read_pos      = PW'(address);
        div_x         = '0;

        unique case (state_reg)
            cfga_pkg::S_IDLE:
            begin
            end
            cfga_pkg::S_CHECK:
            begin
                rlen_next  = rlen_w;
                qlen_next  = qlen_w;
                cs_next    = cs_w;
                ce_next    = PW'(orf_end_reg);
                i_next     = cs_w;
                j_next     = '0;
                total_next = '0;
                if (bounds_bad)
                begin
                    done_next    = 1'b1;
                    failed_next  = 1'b1;
                    penalty_next = '0;
                end
            end
            cfga_pkg::S_LOOP:
            begin
                if (loop_ok)
                begin
                    ca_next       = i_reg;
                    cb_next       = j_reg;
                    cmp_k_next    = 2'd0;
                    cmp_eq_next   = 1'b1;
                    cmp_main_next = 1'b1;
                end
                else
                begin
                    done_next    = 1'b1;
                    failed_next  = 1'b0;
                    penalty_next = (total_reg > TW'(cfga_pkg::PENALTY_MAX))
                                   ? cfga_pkg::PENALTY_MAX : total_reg[16:0];
                end
            end
            cfga_pkg::S_CMP:
            begin
                ref_pos     = ca_reg + PW'(cmp_k_reg);
                read_pos    = cb_reg + PW'(cmp_k_reg);
                cmp_k_next  = cmp_k_reg + 2'd1;
                cmp_eq_next = cmp_eq_now;
                if ((cmp_k_reg != 2'd0) && cmp_main_reg)
                begin
                    r_next[cmp_k_reg - 2'd1] = ref_rdata;
                    q_next[cmp_k_reg - 2'd1] = read_rdata;
                end
                if (cmp_k_reg == 2'd3)
                begin
                    if (cmp_main_reg)
                    begin
                        if (cmp_eq_now)
                        begin
                            i_next = i_reg + PW'(3);
                            j_next = j_reg + PW'(3);
                        end
                        else
                        begin
                            scan_sel_next = 1'b0;
                            scan_k_next   = i_reg + PW'(1);
                            scan_n_next   = PW'(1);
                            scan_b_next   = r_reg[0];
                        end
                    end
                    else
                    begin
                        if (cand_better)
                        begin
                            found_next = 1'b1;
                            best_next  = shift_dist;
                            bdi_next   = di_reg;
                            bdj_next   = dj_reg;
                        end
                        dj_next = (dj_reg == 3'd4) ? 3'd0 : dj_reg + 3'd1;
                        di_next = (dj_reg == 3'd4) ? di_reg + 3'd1 : di_reg;
                    end
                end
            end
            cfga_pkg::S_RUN_FWD:
            begin
                ref_pos  = scan_k_reg;
                read_pos = scan_k_reg;
                if (fwd_stop)
                begin
                    scan_k_next = scan_p;
                end
            end
            cfga_pkg::S_RUN_FWD_W:
            begin
                if (scan_hit)
                begin
                    scan_n_next = scan_n_reg + PW'(1);
                    scan_k_next = scan_k_reg + PW'(1);
                end
                else
                begin
                    scan_k_next = scan_p;
                end
            end
            cfga_pkg::S_RUN_BWD:
            begin
                ref_pos  = scan_k_reg - PW'(1);
                read_pos = scan_k_reg - PW'(1);
            end
            cfga_pkg::S_RUN_BWD_W:
            begin
                if (scan_hit)
                begin
                    scan_n_next = scan_n_reg + PW'(1);
                    scan_k_next = scan_k_reg - PW'(1);
                end
            end
            cfga_pkg::S_RUN_NEXT:
            begin
                if (!scan_sel_reg)
                begin
                    rh_next       = scan_n_reg;
                    scan_sel_next = 1'b1;
                    scan_k_next   = j_reg + PW'(1);
                    scan_n_next   = PW'(1);
                    scan_b_next   = q_reg[0];
                end
                else
                begin
                    if (rh3 && qh3)
                    begin
                        h_next = (rh_reg > scan_n_reg) ? rh_reg : scan_n_reg;
                    end
                    else
                    begin
                        h_next = rh3 ? rh_reg : scan_n_reg;
                    end
                    di_next    = 3'd0;
                    dj_next    = 3'd0;
                    found_next = 1'b0;
                end
            end
            cfga_pkg::S_HOMO_DIV:
            begin
                div_x = h_reg;
            end
            cfga_pkg::S_HOMO_APPLY:
            begin
                total_next = total_reg + TW'(2);
                i_next     = i_reg + skip;
                j_next     = j_reg + skip;
            end
            cfga_pkg::S_CAND:
            begin
                if (cand_end)
                begin
                    if (found_reg)
                    begin
                        total_next = total_reg + TW'(best_reg) + TW'(3);
                        i_next     = i_reg + PW'(1) + PW'(bdi_reg);
                        j_next     = j_reg + PW'(1) + PW'(bdj_reg);
                    end
                end
                else if (!cand_center && cand_in)
                begin
                    ca_next       = ni;
                    cb_next       = nj;
                    cmp_k_next    = 2'd0;
                    cmp_eq_next   = 1'b1;
                    cmp_main_next = 1'b0;
                end
                else
                begin
                    dj_next = (dj_reg == 3'd4) ? 3'd0 : dj_reg + 3'd1;
                    di_next = (dj_reg == 3'd4) ? di_reg + 3'd1 : di_reg;
                end
            end
            cfga_pkg::S_SUBST_D:
            begin
                if (syn)
                begin
                    total_next = total_reg + TW'(1);
                    i_next     = i_reg + PW'(3);
                    j_next     = j_reg + PW'(3);
                end
                else
                begin
                    d_next = (two_j >= (LW+1)'(lval)) ? two_j - (LW+1)'(lval)
                                                      : (LW+1)'(lval) - two_j;
                end
            end
            cfga_pkg::S_SUBST_MUL:
            begin
                dd_next = (2*LW+2)'(d_reg) * (2*LW+2)'(d_reg);
                ll_next = (2*LW)'(lval) * (2*LW)'(lval);
            end
            cfga_pkg::S_SUBST_CMP:
            begin
                total_next = total_reg + (cost5 ? TW'(5) : TW'(4));
                i_next     = i_reg + PW'(3);
                j_next     = j_reg + PW'(3);
            end
            cfga_pkg::S_TERM_A:
            begin
                div_x = i_reg - cs_reg;
            end
            cfga_pkg::S_TERM_B:
            begin
                q1_next = div_q;
                div_x   = j_reg;
            end
            cfga_pkg::S_TERM_C:
            begin
                if (term_fail)
                begin
                    done_next    = 1'b1;
                    failed_next  = 1'b1;
                    penalty_next = '0;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= cfga_pkg::S_IDLE;
            done_reg         <= 1'b0;
            orf_start_reg    <= '0;
            orf_end_reg      <= '0;
            frame_offset_reg <= '0;
            ref_length_reg   <= '0;
            read_length_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    cfga_pkg::REG_ORF_START:    orf_start_reg    <= cfg_data;
                    cfga_pkg::REG_ORF_END:      orf_end_reg      <= cfg_data;
                    cfga_pkg::REG_FRAME_OFFSET: frame_offset_reg <= cfg_data[1:0];
                    cfga_pkg::REG_REF_LENGTH:   ref_length_reg   <= cfg_data;
                    cfga_pkg::REG_READ_LENGTH:  read_length_reg  <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        penalty_reg  <= penalty_next;
        failed_reg   <= failed_next;
        i_reg        <= i_next;
        j_reg        <= j_next;
        cs_reg       <= cs_next;
        ce_reg       <= ce_next;
        rlen_reg     <= rlen_next;
        qlen_reg     <= qlen_next;
        total_reg    <= total_next;
        ca_reg       <= ca_next;
        cb_reg       <= cb_next;
        cmp_k_reg    <= cmp_k_next;
        cmp_eq_reg   <= cmp_eq_next;
        cmp_main_reg <= cmp_main_next;
        r_reg        <= r_next;
        q_reg        <= q_next;
        scan_sel_reg <= scan_sel_next;
        scan_k_reg   <= scan_k_next;
        scan_n_reg   <= scan_n_next;
        scan_b_reg   <= scan_b_next;
        rh_reg       <= rh_next;
        h_reg        <= h_next;
        di_reg       <= di_next;
        dj_reg       <= dj_next;
        found_reg    <= found_next;
        best_reg     <= best_next;
        bdi_reg      <= bdi_next;
        bdj_reg      <= bdj_next;
        d_reg        <= d_next;
        dd_reg       <= dd_next;
        ll_reg       <= ll_next;
        q1_reg       <= q1_next;
    end

endmodule

`default_nettype wire

// File: tb/sv/tb_codon_frame_greedy_aligner_unit.sv
`default_nettype none

module tb_codon_frame_greedy_aligner_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MEM = 16384;
    localparam string AMINO_CODE =
        "FFLLSSSSYY**CC*WLLLLPPPPHHQQRRRRIIIMTTTTNNKKSSRRVVVVAAAADDEEGGGG";

    typedef struct packed {
        logic [16:0] pen;
        logic        fl;
    } outcome_t;

    typedef struct {
        bit          is_cfg;
        logic [2:0]  idx;
        logic [14:0] val;
        logic [1:0]  op;
        logic [13:0] addr;
        logic [7:0]  b;
        bit          typed;
        logic [16:0] pen;
        bit          fl;
    } row_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  opcode;
    logic [13:0] address;
    logic [7:0]  base;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [14:0] cfg_data;
    logic        done;
    logic [16:0] penalty;
    logic        failed;

    codon_frame_greedy_aligner_unit dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .opcode(opcode), .address(address), .base(base),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .done(done), .penalty(penalty), .failed(failed)
    );

    // Shadow copy of the two memories and registers.
    logic [7:0] ref_mem [MEM];
    logic [7:0] rd_mem [MEM];
    bit         ref_ok [MEM];
    bit         rd_ok [MEM];
    int         orf_s, orf_e, frm, ref_len, rd_len;

    // Set when the alignment would touch a byte never loaded.
    int         need_sel;
    int         need_addr;

    outcome_t   score_q[$];
    int         mismatches;
    int         n_items, n_runs, n_fails, n_checked;
    bit         burst;

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial begin
        #50ms;
        $display("** codon_frame_greedy_aligner_unit: FAILED **");
        $finish;
    end

    function automatic logic [7:0] peek(bit rd, int p);
        if (p < 0 || p >= MEM) return 8'd0;
        if (rd) begin
            if (!rd_ok[p] && need_sel == 0) begin
                need_sel = 2;
                need_addr = p;
            end
            return rd_mem[p];
        end
        if (!ref_ok[p] && need_sel == 0) begin
            need_sel = 1;
            need_addr = p;
        end
        return ref_mem[p];
    endfunction

    function automatic int nuc_code(logic [7:0] b);
        case (b)
            "T": return 0;
            "C": return 1;
            "A": return 2;
            "G": return 3;
            default: return -1;
        endcase
    endfunction

    function automatic logic [7:0] residue(bit rd, int p);
        int a, b, c;
        a = nuc_code(peek(rd, p));
        b = nuc_code(peek(rd, p + 1));
        c = nuc_code(peek(rd, p + 2));
        if (a < 0 || b < 0 || c < 0) return "?";
        return AMINO_CODE[a * 16 + b * 4 + c];
    endfunction

    function automatic bit codon_same(int i, int j);
        for (int k = 0; k < 3; k++)
            if (peek(0, i + k) != peek(1, j + k)) return 1'b0;
        return 1'b1;
    endfunction

    function automatic int homo_len(bit rd, int len, int p);
        logic [7:0] b;
        int n, k;
        if (p >= len) return 0;
        b = peek(rd, p);
        n = 1;
        for (k = p + 1; k < len && peek(rd, k) == b; k++) n++;
        for (k = p; k > 0 && peek(rd, k - 1) == b; k--) n++;
        return n;
    endfunction

    function automatic outcome_t score_alignment();
        outcome_t res;
        int rlen, qlen, cs, ce, i, j, total, rh, qh, h, skip, codons;
        int best, bdi, bdj, ni, nj, shift_dist;
        longint lq, d;
        need_sel = 0;
        res.pen = '0;
        res.fl = 1'b1;
        rlen = ref_len > MEM ? MEM : ref_len;
        qlen = rd_len > MEM ? MEM : rd_len;
        if (orf_e > rlen || orf_s >= orf_e) return res;
        cs = orf_s + frm;
        ce = orf_e;
        if (cs + 3 > ce) return res;
        i = cs;
        j = 0;
        total = 0;
        while (i + 2 < ce && j + 2 < qlen) begin
            if (need_sel != 0) return res;
            if (codon_same(i, j)) begin
                i += 3;
                j += 3;
                continue;
            end
            rh = homo_len(0, rlen, i);
            qh = homo_len(1, qlen, j);
            if (rh < 3) rh = 0;
            if (qh < 3) qh = 0;
            if (rh != 0 || qh != 0) begin
                h = rh > qh ? rh : qh;
                skip = (h / 3) * 3;
                if (skip < 3) skip = 3;
                total += 2;
                i += skip;
                j += skip;
                if (i >= ce) break;
                continue;
            end
            best = 999;
            bdi = 0;
            bdj = 0;
            for (int di = -2; di <= 2; di++) begin
                for (int dj = -2; dj <= 2; dj++) begin
                    if (di == 0 && dj == 0) continue;
                    ni = i + 3 + di;
                    nj = j + 3 + dj;
                    if (ni < cs || nj < 0 || ni + 2 >= ce || nj + 2 >= qlen) continue;
                    if (!codon_same(ni, nj)) continue;
                    shift_dist = (di < 0 ? -di : di) + (dj < 0 ? -dj : dj);
                    if (shift_dist < best) begin
                        best = shift_dist;
                        bdi = di;
                        bdj = dj;
                    end
                end
            end
            if (best < 999) begin
                total += best + 3;
                i += 3 + bdi;
                j += 3 + bdj;
            end else begin
                if (residue(0, i) == residue(1, j)) begin
                    total += 1;
                end else begin
                    // Weight 5 near the middle of the read, 4 toward its ends.
                    lq = qlen != 0 ? qlen : 1;
                    d = 2 * longint'(j) - lq;
                    if (d < 0) d = -d;
                    total += (6 * d * d <= lq * lq) ? 5 : 4;
                end
                i += 3;
                j += 3;
            end
            codons = (i - cs) / 3;
            if (j / 3 > codons) codons = j / 3;
            if (codons > 10 && longint'(total) > longint'(codons) * 5) return res;
        end
        res.fl = 1'b0;
        res.pen = total > int'(cfga_pkg::PENALTY_MAX) ? cfga_pkg::PENALTY_MAX : 17'(total);
        return res;
    endfunction

    always @(posedge clk) begin
        if (rst_n && done) begin
            if (score_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: penalty=%0d failed=%0d", penalty, failed);
            end else begin
                outcome_t e;
                e = score_q.pop_front();
                n_checked++;
                if (e.fl) n_fails++;
                if (penalty !== e.pen || failed !== e.fl) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected penalty=%0d failed=%0d, got %0d/%0d",
                                 e.pen, e.fl, penalty, failed);
                end
            end
        end
    end

    function automatic int pick_gap();
        int r;
        if (burst) return 0;
        r = $urandom_range(99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(5, 30);
    endfunction

    function automatic logic [7:0] pick_base();
        if ($urandom_range(29) == 0) return 8'($urandom_range(255));
        return 8'("TCAG" >> (8 * $urandom_range(3)));
    endfunction

    // Presents one item, holds it until accepted, then updates the shadow state.
    task automatic send_item(logic [1:0] op, logic [13:0] a, logic [7:0] b,
                             bit typed, logic [16:0] tpen, bit tfl);
        outcome_t e;
        int g;
        opcode <= op;
        address <= a;
        base <= b;
        start <= 1'b1;
        do @(posedge clk); while (busy);
        n_items++;
        if (op == cfga_pkg::OP_LOAD_REF) begin
            ref_mem[a] = b;
            ref_ok[a] = 1'b1;
        end else if (op == cfga_pkg::OP_LOAD_READ) begin
            rd_mem[a] = b;
            rd_ok[a] = 1'b1;
        end else if (op == cfga_pkg::OP_RUN) begin
            e = score_alignment();
            if (typed) begin
                e.pen = tpen;
                e.fl = tfl;
            end
            score_q = {score_q, e};
            n_runs++;
        end
        g = pick_gap();
        if (g > 0) begin
            start <= 1'b0;
            repeat (g) @(posedge clk);
        end
    endtask

    // Loads any byte the alignment would read before it was ever written, then sends the run.
    task automatic launch_run();
        outcome_t dummy;
        forever begin
            dummy = score_alignment();
            if (need_sel == 0) break;
            send_item(need_sel == 1 ? cfga_pkg::OP_LOAD_REF : cfga_pkg::OP_LOAD_READ,
                      14'(need_addr), pick_base(), 1'b0, '0, 1'b0);
        end
        send_item(cfga_pkg::OP_RUN, 14'($urandom_range(MEM - 1)), 8'($urandom_range(255)),
                  1'b0, '0, 1'b0);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [14:0] v);
        start <= 1'b0;
        @(posedge clk);
        while (score_q.size() != 0 || busy) @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            cfga_pkg::REG_ORF_START:    orf_s = v;
            cfga_pkg::REG_ORF_END:      orf_e = v;
            cfga_pkg::REG_FRAME_OFFSET: frm = v[1:0];
            cfga_pkg::REG_REF_LENGTH:   ref_len = v;
            cfga_pkg::REG_READ_LENGTH:  rd_len = v;
            default: ;
        endcase
    endtask

    task automatic run_directed();
        row_t rows[$];
        rows = '{
            '{0, 0, 0, cfga_pkg::OP_RUN, 14'd0, 8'd0, 1, 17'd0, 1},
            '{0, 0, 0, 2'd3, 14'h3FFF, 8'hFF, 0, 17'd0, 0},
            '{0, 0, 0, cfga_pkg::OP_LOAD_REF, 14'h3FFF, 8'hFF, 0, 17'd0, 0},
            '{0, 0, 0, cfga_pkg::OP_LOAD_READ, 14'h3FFF, 8'h00, 0, 17'd0, 0},
            '{1, cfga_pkg::REG_REF_LENGTH, 15'd3, 0, 0, 0, 0, 0, 0},
            '{1, cfga_pkg::REG_READ_LENGTH, 15'd3, 0, 0, 0, 0, 0, 0},
            '{1, cfga_pkg::REG_ORF_END, 15'd3, 0, 0, 0, 0, 0, 0},
            '{0, 0, 0, cfga_pkg::OP_LOAD_REF, 14'd0, "A", 0, 17'd0, 0},
            '{0, 0, 0, cfga_pkg::OP_LOAD_REF, 14'd1, "T", 0, 17'd0, 0},
            '{0, 0, 0, cfga_pkg::OP_LOAD_REF, 14'd2, "G", 0, 17'd0, 0},
            '{0, 0, 0, cfga_pkg::OP_LOAD_READ, 14'd0, "A", 0, 17'd0, 0},
            '{0, 0, 0, cfga_pkg::OP_LOAD_READ, 14'd1, "T", 0, 17'd0, 0},
            '{0, 0, 0, cfga_pkg::OP_LOAD_READ, 14'd2, "G", 0, 17'd0, 0},
            '{0, 0, 0, cfga_pkg::OP_RUN, 14'd0, 8'd0, 1, 17'd0, 0},
            '{0, 0, 0, cfga_pkg::OP_LOAD_READ, 14'd2, "A", 0, 17'd0, 0},
            '{0, 0, 0, cfga_pkg::OP_RUN, 14'd0, 8'd0, 1, 17'd4, 0},
            '{1, cfga_pkg::REG_ORF_END, 15'd4, 0, 0, 0, 0, 0, 0},
            '{0, 0, 0, cfga_pkg::OP_RUN, 14'd0, 8'd0, 1, 17'd0, 1},
            '{1, cfga_pkg::REG_ORF_END, 15'd3, 0, 0, 0, 0, 0, 0},
            '{1, cfga_pkg::REG_FRAME_OFFSET, 15'd3, 0, 0, 0, 0, 0, 0},
            '{0, 0, 0, cfga_pkg::OP_RUN, 14'd0, 8'd0, 1, 17'd0, 1},
            '{1, cfga_pkg::REG_FRAME_OFFSET, 15'd0, 0, 0, 0, 0, 0, 0},
            '{1, cfga_pkg::REG_ORF_START, 15'h7FFF, 0, 0, 0, 0, 0, 0},
            '{0, 0, 0, cfga_pkg::OP_RUN, 14'd0, 8'd0, 1, 17'd0, 1},
            '{1, cfga_pkg::REG_ORF_START, 15'd0, 0, 0, 0, 0, 0, 0},
            '{1, cfga_pkg::REG_REF_LENGTH, 15'h7FFF, 0, 0, 0, 0, 0, 0},
            '{1, cfga_pkg::REG_READ_LENGTH, 15'h7FFF, 0, 0, 0, 0, 0, 0},
            '{0, 0, 0, cfga_pkg::OP_RUN, 14'd0, 8'd0, 0, 17'd0, 0}
        };
        foreach (rows[k]) begin
            if (rows[k].is_cfg) begin
                write_reg(rows[k].idx, rows[k].val);
            end else begin
                if (rows[k].op == cfga_pkg::OP_RUN && !rows[k].typed) launch_run();
                else send_item(rows[k].op, rows[k].addr, rows[k].b,
                               rows[k].typed, rows[k].pen, rows[k].fl);
            end
        end
    endtask

    // One data set: a reference, a read usually derived from it, then one to four runs.
    task automatic run_phase();
        logic [7:0] rseq[$];
        logic [7:0] qseq[$];
        logic [7:0] b;
        logic [1:0] op_pick;
        int len, rl, ql, s, e, r, nruns;
        burst = ($urandom_range(5) == 0);
        len = ($urandom_range(19) == 0) ? $urandom_range(100, 300) : $urandom_range(9, 90);
        while (rseq.size() < len) begin
            b = pick_base();
            if ($urandom_range(11) == 0) repeat ($urandom_range(3, 7)) rseq = {rseq, b};
            else rseq = {rseq, b};
        end
        if ($urandom_range(9) == 0) begin
            repeat ($urandom_range(6, len + 6)) qseq = {qseq, pick_base()};
        end else begin
            foreach (rseq[k]) begin
                r = $urandom_range(99);
                if (r < 5) qseq = {qseq, pick_base()};
                else if (r < 8) ;
                else if (r < 11) begin
                    qseq = {qseq, pick_base()};
                    qseq = {qseq, rseq[k]};
                end else qseq = {qseq, rseq[k]};
            end
        end
        foreach (rseq[k]) send_item(cfga_pkg::OP_LOAD_REF, 14'(k), rseq[k], 1'b0, '0, 1'b0);
        foreach (qseq[k]) send_item(cfga_pkg::OP_LOAD_READ, 14'(k), qseq[k], 1'b0, '0, 1'b0);
        rl = rseq.size();
        ql = qseq.size();
        r = $urandom_range(14);
        write_reg(cfga_pkg::REG_REF_LENGTH,
                  r == 0 ? 15'h7FFF : r == 1 ? 15'($urandom_range(rl + 4)) : 15'(rl));
        r = $urandom_range(14);
        write_reg(cfga_pkg::REG_READ_LENGTH,
                  r == 0 ? 15'h7FFF : r == 1 ? 15'($urandom_range(ql + 4)) : 15'(ql));
        nruns = $urandom_range(1, 4);
        repeat (nruns) begin
            if ($urandom_range(6) != 0) begin
                s = $urandom_range(rl / 3);
                e = $urandom_range(s + 3 < rl ? s + 3 : rl, rl);
                if (ref_len > MEM && $urandom_range(3) == 0) e = $urandom_range(rl, rl + 24);
            end else begin
                s = $urandom_range(rl + 4);
                e = $urandom_range(rl + 4);
            end
            write_reg(cfga_pkg::REG_ORF_START, 15'(s));
            write_reg(cfga_pkg::REG_ORF_END, 15'(e));
            write_reg(cfga_pkg::REG_FRAME_OFFSET, 15'($urandom_range(3)));
            repeat ($urandom_range(2)) begin
                r = $urandom_range(9);
                if (r < 4) send_item(cfga_pkg::OP_LOAD_REF, 14'($urandom_range(rl - 1)),
                                     pick_base(), 1'b0, '0, 1'b0);
                else if (r < 8) send_item(cfga_pkg::OP_LOAD_READ,
                                          14'($urandom_range(ql > 0 ? ql - 1 : 0)),
                                          pick_base(), 1'b0, '0, 1'b0);
                else begin
                    op_pick = 2'($urandom_range(3));
                    // A run must first have every byte it touches loaded.
                    if (op_pick == cfga_pkg::OP_RUN) launch_run();
                    else send_item(op_pick, 14'($urandom_range(MEM - 1)),
                                   8'($urandom_range(255)), 1'b0, '0, 1'b0);
                end
            end
            launch_run();
        end
    endtask

    initial begin
        rst_n = 1'b0;
        start = 1'b0;
        opcode = cfga_pkg::OP_LOAD_REF;
        address = '0;
        base = '0;
        cfg_we = 1'b0;
        cfg_index = cfga_pkg::REG_ORF_START;
        cfg_data = '0;
        orf_s = 0;
        orf_e = 0;
        frm = 0;
        ref_len = 0;
        rd_len = 0;
        mismatches = 0;
        n_items = 0;
        n_runs = 0;
        n_fails = 0;
        n_checked = 0;
        burst = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        run_directed();
        while (n_items < 1900) run_phase();
        start <= 1'b0;
        while (score_q.size() != 0) @(posedge clk);
        repeat (50) @(posedge clk);
        $display("Sent %0d items including %0d alignment runs; %0d results checked,", n_items,
                 n_runs, n_checked);
        $display("%0d of them reporting failure; %0d mismatches.", n_fails, mismatches);
        if (mismatches == 0 && score_q.size() == 0)
            $display("** codon_frame_greedy_aligner_unit: PASSED **");
        else
            $display("** codon_frame_greedy_aligner_unit: FAILED **");
        $finish;
    end

endmodule

`default_nettype wire
